[rtl/arsd_pkg.sv]
// ----------------------------------------------------------------------------
// arsd_pkg
// Shared types and constants of the angle rate start detector.
// ----------------------------------------------------------------------------
package arsd_pkg;

    localparam int ANGLE_WIN_MAX_DEF = 64;
    localparam int SMOOTH_MAX_DEF    = 32;
    localparam int DETECT_MAX_DEF    = 32;

    localparam int ANGLE_W = 32;
    localparam int DIFF_W  = 33;
    localparam int IDX_W   = 32;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [6:0] FRAME_RST  = 7'd1;
    localparam logic [5:0] SMOOTH_RST = 6'd20;
    localparam logic [5:0] DETECT_RST = 6'd8;
    localparam logic [7:0] HOLD_RST   = 8'd20;

    localparam logic [1:0] FLIP_LIMIT = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME  = 2'd0,
        CFG_SMOOTH = 2'd1,
        CFG_DETECT = 2'd2,
        CFG_HOLD   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SGN_NONE = 2'd0,
        SGN_POS  = 2'd1,
        SGN_NEG  = 2'd2
    } sign_t;

    typedef enum logic {
        F_IDLE,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SUB,
        B_DIV,
        B_DET,
        B_OUT
    } back_state_t;

    // One classified sample handed from the front to the back.
    typedef struct packed {
        logic                     has_diff;
        logic signed [DIFF_W-1:0] diff;
    } diff_item_t;

    // Window resets caused by register writes.
    typedef struct packed {
        logic clr_angle;
        logic clr_diff;
        logic clr_smooth;
    } win_ctl_t;

    typedef struct packed {
        logic started;
        logic unstable;
    } det_stat_t;

endpackage

[rtl/arsd_if.sv]
// ----------------------------------------------------------------------------
// arsd_sample_if / arsd_result_if
// Valid/ready channels of the angle rate start detector.
// ----------------------------------------------------------------------------
interface arsd_sample_if
    import arsd_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface arsd_result_if
    import arsd_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     diff_valid;
    logic signed [DIFF_W-1:0] smoothed_diff;
    logic                     started;
    logic [IDX_W-1:0]         start_index;
    logic                     unstable;

    modport source (output valid, output diff_valid, output smoothed_diff, output started,
                    output start_index, output unstable, input ready);
    modport sink   (input valid, input diff_valid, input smoothed_diff, input started,
                    input start_index, input unstable, output ready);
endinterface

[rtl/angle_rate_start_detector.sv]
// ----------------------------------------------------------------------------
// angle_rate_start_detector
// Smoothed angle rate with slope sign flip start detection.
// ----------------------------------------------------------------------------
// Usage: angle samples arrive on the sample channel, one transaction per
// frame. Each accepted sample yields exactly one transaction on the result
// channel carrying the smoothed difference (when one was formed) and the
// sticky started and unstable flags.
// The front end takes a sample, registers it with the oldest sample of its
// window and forms the windowed difference, then hands it over a two-entry
// queue to the back end. The back end updates the running sum, divides it by
// the fill count in a one-bit-per-cycle divider and tracks the slope sign.
// The serial divider sets the sustained rate. Samples without a difference
// skip the divider and go straight to the result.
// Reset empties all windows, clears the flags and loads the register defaults.
// When the receiver stalls the result register holds and the queue fills; the
// front end then stops accepting samples. Configuration writes are meant for
// idle periods and empty the window they belong to.
// ----------------------------------------------------------------------------
module angle_rate_start_detector
    import arsd_pkg::*;
#(
    parameter int ANGLE_WIN_MAX = ANGLE_WIN_MAX_DEF,
    parameter int SMOOTH_MAX    = SMOOTH_MAX_DEF,
    parameter int DETECT_MAX    = DETECT_MAX_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    arsd_sample_if.sink          sample,
    arsd_result_if.source        result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int NW = $clog2(ANGLE_WIN_MAX + 1);
    localparam int MW = $clog2(SMOOTH_MAX + 1);
    localparam int DW = $clog2(DETECT_MAX + 1);

    logic [6:0] frame_reg;
    logic [5:0] smooth_reg;
    logic [5:0] detect_reg;
    logic [7:0] hold_reg;
    win_ctl_t   ctl;

    logic [NW-1:0] frame_n;
    logic [MW-1:0] smooth_m;
    logic [DW-1:0] detect_d;

    logic       push_valid, push_ready, pop_valid, pop_ready;
    diff_item_t push_item, pop_item;
    det_stat_t  stat;

    always_comb
    begin
        ctl = '0;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FRAME:  ctl.clr_angle  = 1'b1;
                CFG_SMOOTH: ctl.clr_diff   = 1'b1;
                CFG_DETECT: ctl.clr_smooth = 1'b1;
                CFG_HOLD:   ctl = '0;
                default:    ctl = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg  <= FRAME_RST;
            smooth_reg <= SMOOTH_RST;
            detect_reg <= DETECT_RST;
            hold_reg   <= HOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FRAME:  frame_reg  <= cfg_data[6:0];
                CFG_SMOOTH: smooth_reg <= cfg_data[5:0];
                CFG_DETECT: detect_reg <= cfg_data[5:0];
                CFG_HOLD:   hold_reg   <= cfg_data;
                default:    hold_reg   <= hold_reg;
            endcase
        end
    end

    // Clamp the registers to the supported window sizes.
    always_comb
    begin
        if (frame_reg == 7'd0)
            frame_n = NW'(1);
        else if (32'(frame_reg) > ANGLE_WIN_MAX)
            frame_n = NW'(ANGLE_WIN_MAX);
        else
            frame_n = NW'(frame_reg);
        if (smooth_reg == 6'd0)
            smooth_m = MW'(1);
        else if (32'(smooth_reg) > SMOOTH_MAX)
            smooth_m = MW'(SMOOTH_MAX);
        else
            smooth_m = MW'(smooth_reg);
        if (detect_reg < 6'd2)
            detect_d = DW'(2);
        else if (32'(detect_reg) > DETECT_MAX)
            detect_d = DW'(DETECT_MAX);
        else
            detect_d = DW'(detect_reg);
    end

    arsd_front #(
        .ANGLE_WIN_MAX (ANGLE_WIN_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .frame_n    (frame_n),
        .ctl        (ctl),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    arsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    arsd_back #(
        .SMOOTH_MAX (SMOOTH_MAX),
        .DETECT_MAX (DETECT_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .smooth_m   (smooth_m),
        .detect_d   (detect_d),
        .hold_limit (hold_reg),
        .ctl        (ctl),
        .stat       (stat),
        .result     (result)
    );

    // Detection freezes on either flag, so both can never be set.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.started && stat.unstable))
        else $error("started and unstable both set");

    assert property (@(posedge clk) disable iff (!rst_n)
        stat.started |=> stat.started)
        else $error("started flag dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        stat.unstable |=> stat.unstable)
        else $error("unstable flag dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.diff_valid) |-> (result.smoothed_diff == '0))
        else $error("smoothed difference without a difference");

endmodule

[rtl/arsd_front.sv]
// ----------------------------------------------------------------------------
// arsd_front
// Accepts angle samples, keeps the sample window and forms the difference.
// ----------------------------------------------------------------------------
module arsd_front
    import arsd_pkg::*;
#(
    parameter int ANGLE_WIN_MAX = ANGLE_WIN_MAX_DEF,
    localparam int AW = (ANGLE_WIN_MAX > 1) ? $clog2(ANGLE_WIN_MAX) : 1,
    localparam int NW = $clog2(ANGLE_WIN_MAX + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    arsd_sample_if.sink       sample,
    input  logic [NW-1:0]     frame_n,
    input  win_ctl_t          ctl,
    output logic              push_valid,
    input  logic              push_ready,
    output diff_item_t        push_item
);

    localparam logic [NW-1:0] MAX_N = NW'(ANGLE_WIN_MAX);
    localparam logic [AW-1:0] LAST  = AW'(ANGLE_WIN_MAX - 1);

    logic signed [ANGLE_W-1:0] angle_mem [ANGLE_WIN_MAX];

    front_state_t              state_reg, state_next;
    logic [AW-1:0]             wr_reg;
    logic [NW-1:0]             fill_reg;
    logic                      has_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic signed [ANGLE_W-1:0] old_reg;

    logic                      accept;
    logic [NW-1:0]             fill_inc;
    logic                      has_next;
    logic [NW:0]               rd_sum;
    logic [AW-1:0]             rd_addr;

    assign accept = sample.valid && sample.ready;
    assign fill_inc = (fill_reg == MAX_N) ? MAX_N : fill_reg + NW'(1);
    assign has_next = (fill_inc >= frame_n);

    // Oldest sample of the window sits frame_n - 1 places behind the write slot.
    always_comb
    begin
        if ({1'b0, wr_reg} >= AW'(0) + (frame_n - NW'(1)))
            rd_sum = (NW+1)'(wr_reg) - (NW+1)'(frame_n - NW'(1));
        else
            rd_sum = (NW+1)'(wr_reg) + (NW+1)'(ANGLE_WIN_MAX) - (NW+1)'(frame_n - NW'(1));
        rd_addr = rd_sum[AW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        sample.ready = 1'b0;
        push_valid = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                sample.ready = 1'b1;
                if (sample.valid)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        push_item.has_diff = has_reg;
        if (!has_reg || frame_n == NW'(1))
            push_item.diff = '0;
        else
            push_item.diff = DIFF_W'(angle_reg) - DIFF_W'(old_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            wr_reg    <= '0;
            fill_reg  <= '0;
            has_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.clr_angle)
                fill_reg <= '0;
            else if (accept)
            begin
                wr_reg   <= (wr_reg == LAST) ? '0 : wr_reg + AW'(1);
                fill_reg <= has_next ? frame_n - NW'(1) : fill_inc;
                has_reg  <= has_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            angle_mem[wr_reg] <= sample.angle;
            old_reg           <= angle_mem[rd_addr];
            angle_reg         <= sample.angle;
        end
    end

endmodule

[rtl/arsd_queue.sv]
// ----------------------------------------------------------------------------
// arsd_queue
// Two-entry queue between the sample front end and the averaging back end.
// ----------------------------------------------------------------------------
module arsd_queue
    import arsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  diff_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output diff_item_t pop_item
);

    diff_item_t slot_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_reg <= ~wr_reg;
            if (do_pop)
                rd_reg <= ~rd_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_item;
    end

endmodule

[rtl/arsd_back.sv]
// ----------------------------------------------------------------------------
// arsd_back
// Moving average with a serial divider, slope sign tracking and the result.
// ----------------------------------------------------------------------------
module arsd_back
    import arsd_pkg::*;
#(
    parameter int SMOOTH_MAX = SMOOTH_MAX_DEF,
    parameter int DETECT_MAX = DETECT_MAX_DEF,
    localparam int MW = $clog2(SMOOTH_MAX + 1),
    localparam int DW = $clog2(DETECT_MAX + 1),
    localparam int SA = (SMOOTH_MAX > 1) ? $clog2(SMOOTH_MAX) : 1,
    localparam int DA = $clog2(DETECT_MAX),
    localparam int SUM_W = DIFF_W + MW,
    localparam int CW = $clog2(SUM_W + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  diff_item_t    pop_item,
    input  logic [MW-1:0] smooth_m,
    input  logic [DW-1:0] detect_d,
    input  logic [7:0]    hold_limit,
    input  win_ctl_t      ctl,
    output det_stat_t     stat,
    arsd_result_if.source result
);

    localparam logic [SA-1:0] S_LAST = SA'(SMOOTH_MAX - 1);
    localparam logic [DA-1:0] D_LAST = DA'(DETECT_MAX - 1);

    logic signed [DIFF_W-1:0] diff_mem   [SMOOTH_MAX];
    logic signed [DIFF_W-1:0] smooth_mem [DETECT_MAX];

    back_state_t              state_reg, state_next;
    diff_item_t               item_reg;
    logic signed [DIFF_W-1:0] drop_reg;
    logic signed [DIFF_W-1:0] oldest_reg;
    logic [SA-1:0]            dwr_reg;
    logic [MW-1:0]            dfill_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [DA-1:0]            swr_reg;
    logic [DW-1:0]            sfill_reg;
    logic [SUM_W-1:0]         quo_reg;
    logic [MW:0]              rem_reg;
    logic [MW-1:0]            div_reg;
    logic [CW-1:0]            cnt_reg;
    logic                     neg_reg;
    logic signed [DIFF_W-1:0] avg_reg;
    sign_t                    last_sign_reg;
    logic [IDX_W-1:0]         slope_idx_reg;
    logic [1:0]               flips_reg;
    logic [7:0]               hold_reg;
    logic                     start_reg, error_reg;
    logic [IDX_W-1:0]         found_reg;
    logic                     out_valid_reg;
    logic                     out_dv_reg;
    logic signed [DIFF_W-1:0] out_avg_reg;
    logic                     out_start_reg, out_err_reg;
    logic [IDX_W-1:0]         out_idx_reg;

    logic                     do_sub;
    logic signed [SUM_W-1:0]  sum_next;
    logic [MW-1:0]            dfill_next;
    logic [SA:0]              drd_sum;
    logic [SA-1:0]            drd_addr;
    logic [DA:0]              srd_sum;
    logic [DA-1:0]            srd_addr;
    logic [MW:0]              rem_sh;
    logic                     rem_ge;
    logic [SUM_W-1:0]         quo_signed;
    logic signed [DIFF_W-1:0] avg_now;
    logic signed [DIFF_W:0]   slope;
    sign_t                    sign_now;
    logic [DW-1:0]            sfill_inc;
    logic                     detect_on;
    logic [IDX_W-1:0]         idx_next;
    logic                     flip;
    logic [1:0]               flips_next;
    logic                     out_load;

    assign pop_ready = (state_reg == B_IDLE);
    assign out_load  = (state_reg == B_OUT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        if ({1'b0, dwr_reg} >= (SA+1)'(smooth_m))
            drd_sum = (SA+1)'(dwr_reg) - (SA+1)'(smooth_m);
        else
            drd_sum = (SA+1)'(dwr_reg) + (SA+1)'(SMOOTH_MAX) - (SA+1)'(smooth_m);
        drd_addr = drd_sum[SA-1:0];
        if ((DA+1)'(swr_reg) >= (DA+1)'(detect_d - DW'(2)))
            srd_sum = (DA+1)'(swr_reg) - (DA+1)'(detect_d - DW'(2));
        else
            srd_sum = (DA+1)'(swr_reg) + (DA+1)'(DETECT_MAX) - (DA+1)'(detect_d - DW'(2));
        srd_addr = srd_sum[DA-1:0];
    end

    // Running sum update; the value leaving the window is registered in B_IDLE, ahead of B_SUB.
    assign do_sub     = (dfill_reg >= smooth_m);
    assign dfill_next = do_sub ? smooth_m : dfill_reg + MW'(1);
    assign sum_next   = sum_reg - (do_sub ? SUM_W'(drop_reg) : SUM_W'(0))
                        + SUM_W'(item_reg.diff);

    // Restoring division of the sum magnitude by the fill count, one bit a cycle.
    assign rem_sh = {rem_reg[MW-1:0], quo_reg[SUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, div_reg});

    assign quo_signed = neg_reg ? SUM_W'(0) - quo_reg : quo_reg;
    assign avg_now    = quo_signed[DIFF_W-1:0];

    assign detect_on = !start_reg && !error_reg;
    assign sfill_inc = sfill_reg + DW'(1);
    assign slope     = (detect_d == DW'(2)) ? '0
                       : (DIFF_W+1)'(avg_now) - (DIFF_W+1)'(oldest_reg);
    always_comb
    begin
        if (slope > 0)
            sign_now = SGN_POS;
        else if (slope < 0)
            sign_now = SGN_NEG;
        else
            sign_now = SGN_NONE;
    end
    assign idx_next   = (&slope_idx_reg) ? slope_idx_reg : slope_idx_reg + IDX_W'(1);
    assign flip       = (idx_next > IDX_W'(1)) && (sign_now != SGN_NONE)
                        && (last_sign_reg != SGN_NONE) && (sign_now != last_sign_reg);
    assign flips_next = (flip && flips_reg != 2'd3) ? flips_reg + 2'd1 : flips_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
                if (pop_valid)
                    state_next = pop_item.has_diff ? B_SUB : B_OUT;
            B_SUB:  state_next = B_DIV;
            B_DIV:
                if (cnt_reg == CW'(1))
                    state_next = B_DET;
            B_DET:  state_next = B_OUT;
            B_OUT:
                if (out_load)
                    state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            dwr_reg       <= '0;
            dfill_reg     <= '0;
            sum_reg       <= '0;
            swr_reg       <= '0;
            sfill_reg     <= '0;
            last_sign_reg <= SGN_NONE;
            slope_idx_reg <= '0;
            flips_reg     <= '0;
            hold_reg      <= '0;
            start_reg     <= 1'b0;
            error_reg     <= 1'b0;
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.clr_diff)
            begin
                dfill_reg <= '0;
                sum_reg   <= '0;
            end
            if (ctl.clr_smooth)
                sfill_reg <= '0;
            if (state_reg == B_SUB)
            begin
                dfill_reg <= dfill_next;
                sum_reg   <= sum_next;
                dwr_reg   <= (dwr_reg == S_LAST) ? '0 : dwr_reg + SA'(1);
                cnt_reg   <= CW'(SUM_W);
            end
            if (state_reg == B_DIV)
                cnt_reg <= cnt_reg - CW'(1);
            if (state_reg == B_DET && detect_on)
            begin
                swr_reg <= (swr_reg == D_LAST) ? '0 : swr_reg + DA'(1);
                if (sfill_inc < detect_d)
                    sfill_reg <= sfill_inc;
                else
                begin
                    sfill_reg     <= detect_d - DW'(1);
                    slope_idx_reg <= idx_next;
                    flips_reg     <= flips_next;
                    last_sign_reg <= sign_now;
                    if (flips_next == FLIP_LIMIT)
                    begin
                        if (hold_reg < hold_limit)
                            hold_reg <= hold_reg + 8'd1;
                        else
                        begin
                            start_reg <= 1'b1;
                            found_reg <= idx_next;
                        end
                    end
                    if (flips_next > FLIP_LIMIT)
                        error_reg <= 1'b1;
                end
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && pop_valid)
        begin
            item_reg <= pop_item;
            drop_reg <= diff_mem[drd_addr];
            avg_reg  <= '0;
        end
        if (state_reg == B_SUB)
        begin
            diff_mem[dwr_reg] <= item_reg.diff;
            oldest_reg        <= smooth_mem[srd_addr];
            neg_reg           <= sum_next[SUM_W-1];
            quo_reg           <= sum_next[SUM_W-1] ? SUM_W'(0) - sum_next : sum_next;
            rem_reg           <= '0;
            div_reg           <= dfill_next;
        end
        if (state_reg == B_DIV)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_sh - {1'b0, div_reg} : rem_sh;
            if (cnt_reg == CW'(1))
                avg_reg <= '0;
        end
        if (state_reg == B_DET)
        begin
            avg_reg <= avg_now;
            if (detect_on)
                smooth_mem[swr_reg] <= avg_now;
        end
        if (out_load)
        begin
            out_dv_reg    <= item_reg.has_diff;
            out_avg_reg   <= item_reg.has_diff ? avg_reg : '0;
            out_start_reg <= start_reg;
            out_idx_reg   <= start_reg ? found_reg : '0;
            out_err_reg   <= error_reg;
        end
    end

    // The slope is taken from the quotient directly in B_DET; the average is
    // registered there only for the result.
    assign result.valid         = out_valid_reg;
    assign result.diff_valid    = out_dv_reg;
    assign result.smoothed_diff = out_avg_reg;
    assign result.started       = out_start_reg;
    assign result.start_index   = out_idx_reg;
    assign result.unstable      = out_err_reg;

    assign stat.started  = start_reg;
    assign stat.unstable = error_reg;

endmodule

[tb/arsd_checker.sv]
// ----------------------------------------------------------------------------
// arsd_checker
// Predicts every result of the angle rate start detector from the accepted
// samples and the register writes, and compares it with the result channel.
// ----------------------------------------------------------------------------
module arsd_checker
    import arsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    arsd_sample_if               smp,
    arsd_result_if               res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   pending
);

    typedef struct packed {
        logic              diff_valid;
        logic [DIFF_W-1:0] smoothed_diff;
        logic              started;
        logic [IDX_W-1:0]  start_index;
        logic              unstable;
    } rate_result_t;

    rate_result_t result_q[$];

    int          frame_reg, smooth_reg, detect_reg, hold_reg;
    longint      angle_hist[ANGLE_WIN_MAX_DEF];
    int          angle_wr, angle_cnt;
    longint      diff_hist[SMOOTH_MAX_DEF];
    int          diff_wr, diff_cnt;
    longint      diff_acc;
    longint      smooth_hist[DETECT_MAX_DEF];
    int          smooth_wr, smooth_cnt;
    sign_t       prev_sign;
    logic [31:0] slope_count;
    int          flips, hold_count;
    bit          start_seen, error_seen;
    logic [31:0] start_at;

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int back(input int wr, input int k, input int size);
        return (wr + 2 * size - 1 - k) % size;
    endfunction

    // Feeds one smoothed value into the slope window and updates the flip tracking.
    function automatic void track_slope(input longint value);
        int     d;
        longint slope;
        sign_t  sgn;
        d = clamp(detect_reg, 2, DETECT_MAX_DEF);
        smooth_hist[smooth_wr] = value;
        smooth_wr = (smooth_wr + 1) % DETECT_MAX_DEF;
        smooth_cnt++;
        if (smooth_cnt < d)
            return;
        smooth_cnt = d - 1;
        slope = smooth_hist[back(smooth_wr, 0, DETECT_MAX_DEF)]
              - smooth_hist[back(smooth_wr, d - 2, DETECT_MAX_DEF)];
        if (slope_count != 32'hFFFF_FFFF)
            slope_count++;
        sgn = (slope > 0) ? SGN_POS : ((slope < 0) ? SGN_NEG : SGN_NONE);
        if (slope_count > 1 && sgn != SGN_NONE && prev_sign != SGN_NONE && sgn != prev_sign)
            if (flips < 3)
                flips++;
        prev_sign = sgn;
        if (flips == 2)
        begin
            if (hold_count < hold_reg)
                hold_count++;
            else
            begin
                start_seen = 1;
                start_at   = slope_count;
            end
        end
        if (flips > 2)
            error_seen = 1;
    endfunction

    function automatic rate_result_t predict_rate(input logic signed [ANGLE_W-1:0] a);
        rate_result_t r;
        int     n, m;
        longint diff, avg;
        n = clamp(frame_reg, 1, ANGLE_WIN_MAX_DEF);
        m = clamp(smooth_reg, 1, SMOOTH_MAX_DEF);
        avg = 0;
        r.diff_valid = 0;
        angle_hist[angle_wr] = longint'(a);
        angle_wr = (angle_wr + 1) % ANGLE_WIN_MAX_DEF;
        if (angle_cnt < ANGLE_WIN_MAX_DEF)
            angle_cnt++;
        if (angle_cnt >= n)
        begin
            diff = angle_hist[back(angle_wr, 0, ANGLE_WIN_MAX_DEF)]
                 - angle_hist[back(angle_wr, n - 1, ANGLE_WIN_MAX_DEF)];
            angle_cnt = n - 1;
            if (diff_cnt >= m)
            begin
                diff_acc -= diff_hist[back(diff_wr, m - 1, SMOOTH_MAX_DEF)];
                diff_cnt = m;
            end
            else
                diff_cnt++;
            diff_hist[diff_wr] = diff;
            diff_wr = (diff_wr + 1) % SMOOTH_MAX_DEF;
            diff_acc += diff;
            avg = diff_acc / longint'(diff_cnt);
            r.diff_valid = 1;
            if (!start_seen && !error_seen)
                track_slope(avg);
        end
        r.smoothed_diff = avg[DIFF_W-1:0];
        r.started       = start_seen;
        r.start_index   = start_seen ? start_at : '0;
        r.unstable      = error_seen;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rate_result_t got, want;
        if (!rst_n)
        begin
            frame_reg   = FRAME_RST;
            smooth_reg  = SMOOTH_RST;
            detect_reg  = DETECT_RST;
            hold_reg    = HOLD_RST;
            angle_wr    = 0;
            angle_cnt   = 0;
            diff_wr     = 0;
            diff_cnt    = 0;
            diff_acc    = 0;
            smooth_wr   = 0;
            smooth_cnt  = 0;
            prev_sign   = SGN_NONE;
            slope_count = '0;
            flips       = 0;
            hold_count  = 0;
            start_seen  = 0;
            error_seen  = 0;
            start_at    = '0;
            result_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FRAME:
                    begin
                        frame_reg = cfg_data[6:0];
                        angle_cnt = 0;
                    end
                    CFG_SMOOTH:
                    begin
                        smooth_reg = cfg_data[5:0];
                        diff_cnt   = 0;
                        diff_acc   = 0;
                    end
                    CFG_DETECT:
                    begin
                        detect_reg = cfg_data[5:0];
                        smooth_cnt = 0;
                    end
                    CFG_HOLD:
                        hold_reg = cfg_data;
                    default: ;
                endcase
            end
            if (smp.valid && smp.ready)
                result_q.insert(result_q.size(), predict_rate(smp.angle));
            if (res.valid && res.ready)
            begin
                got.diff_valid    = res.diff_valid;
                got.smoothed_diff = res.smoothed_diff;
                got.started       = res.started;
                got.start_index   = res.start_index;
                got.unstable      = res.unstable;
                if (result_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected result transaction dv=%0b sd=%0h st=%0b si=%0d un=%0b",
                                 got.diff_valid, got.smoothed_diff, got.started,
                                 got.start_index, got.unstable);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("ERROR: result mismatch at %0t", $realtime);
                            $display("  expected dv=%0b sd=%0h st=%0b si=%0d un=%0b",
                                     want.diff_valid, want.smoothed_diff, want.started,
                                     want.start_index, want.unstable);
                            $display("  actual   dv=%0b sd=%0h st=%0b si=%0d un=%0b",
                                     got.diff_valid, got.smoothed_diff, got.started,
                                     got.start_index, got.unstable);
                        end
                    end
                end
            end
            pending = result_q.size();
        end
    end

endmodule

[tb/angle_rate_start_detector_test.sv]
// ----------------------------------------------------------------------------
// angle_rate_start_detector_test
// Drives angle samples and register settings into the detector under several
// idle and stall patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module angle_rate_start_detector_test;
    import arsd_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int SETTLE       = 60;

    logic                 clk = 0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   errors, pending;
    int                   idle_pct, stall_pct;
    int                   hold_asked, hold_served, hold_left;
    int                   cycles;

    arsd_sample_if smp_ch ();
    arsd_result_if res_ch ();

    angle_rate_start_detector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    arsd_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp       (smp_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always #10 clk = ~clk;

    // Receiver; a requested long hold-off is counted out here.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            hold_served  = 0;
            hold_left    = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else if (hold_asked != hold_served)
        begin
            hold_served++;
            hold_left = 400;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_angle(input logic [ANGLE_W-1:0] a);
        while ($urandom_range(99) < idle_pct)
        begin
            smp_ch.valid <= 1'b0;
            @(posedge clk);
        end
        smp_ch.valid <= 1'b1;
        smp_ch.angle <= a;
        @(posedge clk);
        while (!smp_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        smp_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] frame, input logic [7:0] smooth,
                                input logic [7:0] detect, input logic [7:0] hold);
        logic [7:0] vals[4];
        vals = '{frame, smooth, detect, hold};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_pace(input int mode);
        case (mode % 4)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 87; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 87; end
            default: begin idle_pct = 38; stall_pct = 38; end
        endcase
    endtask

    // Piecewise constant acceleration with two sign changes, so the slope of the
    // smoothed rate flips exactly twice and the start condition can be reached.
    task automatic send_swing(input int count);
        longint pos, vel, acc;
        int     seg1, seg2;
        acc  = 64 * $urandom_range(1, 8);
        seg1 = $urandom_range(20, 40);
        seg2 = seg1 + $urandom_range(40, 80);
        pos  = $urandom_range(0, 100000) - 50000;
        vel  = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i < seg1)
                vel += acc;
            else if (i < seg2)
                vel -= acc;
            else
                vel += acc;
            pos += vel;
            send_angle(pos[31:0]);
        end
    endtask

    task automatic send_noise(input int count);
        logic [31:0] walk;
        walk = $urandom;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 30)
                walk = $urandom;
            else
                walk = walk + $urandom_range(0, 4000) - 2000;
            send_angle(walk);
        end
    endtask

    initial
    begin
        logic [31:0] extremes[10];
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        smp_ch.valid = 1'b0;
        smp_ch.angle = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_asked   = 0;
        cycles       = 0;
        extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                     32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'h8000_0000};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default registers: a one-sample window gives a zero difference.
        for (int i = 0; i < 8; i++)
            send_angle(extremes[i]);
        drain();
        // Extreme differences; the wide detection window keeps slopes from forming.
        write_config(8'd3, 8'd2, 8'd32, 8'd0);
        foreach (extremes[i])
            send_angle(extremes[i]);
        drain();
        // Window not yet full: no difference.
        write_config(8'd64, 8'd1, 8'd32, 8'd0);
        for (int i = 0; i < 5; i++)
            send_angle(extremes[i]);
        drain();

        write_config(8'd4, 8'd4, 8'd4, 8'($urandom_range(0, 10)));
        set_pace(0);
        send_swing(220);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       write_config(8'd1, 8'd1, 8'd2, 8'd0);
                1:       write_config(8'd64, 8'd32, 8'd32, 8'd255);
                2:       write_config(8'd0, 8'd0, 8'd0, 8'd7);
                3:       write_config(8'd127, 8'd63, 8'd63, 8'd128);
                default: write_config(8'($urandom_range(1, 16)), 8'($urandom_range(1, 32)),
                                      8'($urandom_range(2, 32)), 8'($urandom));
            endcase
            set_pace(ph);
            if (ph == 4)
            begin
                // Long receiver hold-off with the sender still busy fills the block.
                hold_asked++;
                send_noise(30);
                drain();
                send_noise(180);
            end
            else if (ph == 5)
            begin
                send_noise(100);
                drain();
                send_noise(110);
            end
            else
                send_noise(210);
            drain();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/arsd_pkg.sv
rtl/arsd_if.sv
rtl/arsd_front.sv
rtl/arsd_queue.sv
rtl/arsd_back.sv
rtl/angle_rate_start_detector.sv
tb/arsd_checker.sv
tb/angle_rate_start_detector_test.sv
